FILE: sv/systematic_resampler_macros.svh
// Assertion shorthands for the resampler; all sample on clk and go quiet in reset.
`ifndef SYSTEMATIC_RESAMPLER_MACROS_SVH
`define SYSTEMATIC_RESAMPLER_MACROS_SVH

// Same-cycle implication.
`define SR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/sr_pkg.sv
package sr_pkg;

	localparam int unsigned MAX_PARTICLES_DEF = 4096;
	localparam int unsigned MAX_OUT_DEF       = 64;

	localparam int unsigned ONE_Q24   = 2 ** 24;
	localparam int unsigned NUM_OUT_W = 7;
	localparam int unsigned UNI_W     = 24;
	localparam int unsigned WGT_W     = 25;
	localparam int unsigned STEP_W    = 25;
	localparam int unsigned SUM_W     = 26;
	localparam int unsigned ANC_W     = 12;
	localparam int unsigned SLOT_W    = 6;

	localparam logic [NUM_OUT_W-1:0] NUM_OUT_RST = NUM_OUT_W'(64);
	localparam logic [SUM_W-1:0]     SUM_MAX     = {SUM_W{1'b1}};

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;   // take an input beat
		logic mul;      // form the starting threshold
		logic add;      // accumulate the weight
		logic emit;     // load one result into the output register
		logic pidx_inc; // advance the particle index
	} sr_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic in_first; // first bit of the beat on offer
		logic full;     // all slots of the run filled
		logic hit;      // threshold within sum and a slot free
		logic last;     // the pending result ends this weight's burst
		logic out_free; // output register can take a result
	} sr_stat_t;

endpackage

FILE: sv/sr_ctrl.sv
module sr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sr_pkg::sr_stat_t stat,
	output sr_pkg::sr_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_ADD  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = stat.in_first ? ST_MUL : ST_ADD;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				// drop the weight once the run is complete
				cmd.add = !stat.full;
				state_d = stat.full ? ST_IDLE : ST_EMIT;
			end
			ST_EMIT: begin
				if (!stat.hit) begin
					cmd.pidx_inc = 1'b1;
					state_d      = ST_IDLE;
				end else if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.last) begin
						cmd.pidx_inc = 1'b1;
						state_d      = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: sv/sr_dpath.sv
module sr_dpath #(
	parameter int unsigned MAX_PARTICLES = sr_pkg::MAX_PARTICLES_DEF,
	parameter int unsigned MAX_OUT       = sr_pkg::MAX_OUT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [sr_pkg::NUM_OUT_W-1:0]   cfg_wr_data,
	input  logic                           first,
	input  logic [sr_pkg::UNI_W-1:0]       uniform,
	input  logic [sr_pkg::WGT_W-1:0]       weight,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [sr_pkg::ANC_W-1:0]       ancestor,
	output logic [sr_pkg::SLOT_W-1:0]      slot,
	output logic                           last_of_item,
	output logic                           run_done,
	input  sr_pkg::sr_cmd_t                cmd,
	output sr_pkg::sr_stat_t               stat
);

	localparam int unsigned NW        = sr_pkg::NUM_OUT_W;
	localparam int unsigned SW        = sr_pkg::SUM_W;
	localparam int unsigned STW       = sr_pkg::STEP_W;
	localparam int unsigned PW        = sr_pkg::UNI_W + sr_pkg::STEP_W;
	localparam int unsigned PIDX_W    = $clog2(MAX_PARTICLES);
	localparam int unsigned TAB_IDX_W = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
	localparam logic [NW-1:0]     N_MAX    = NW'(MAX_OUT);
	localparam logic [STW-1:0]    STEP_RST = STW'(sr_pkg::ONE_Q24 / MAX_OUT);
	localparam logic [PIDX_W-1:0] PIDX_TOP = PIDX_W'(MAX_PARTICLES - 1);

	logic [NW-1:0]             num_out_q;
	logic [STW-1:0]            step_q;
	logic [sr_pkg::UNI_W-1:0]  uni_q;
	logic [sr_pkg::WGT_W-1:0]  wgt_q;
	logic [SW-1:0]             sum_q;
	logic [SW-1:0]             thr_q;
	logic [NW-1:0]             filled_q;
	logic [PIDX_W-1:0]         pidx_q;
	logic                      out_valid_q;
	logic [sr_pkg::ANC_W-1:0]  anc_q;
	logic [sr_pkg::SLOT_W-1:0] slot_q;
	logic                      last_q;
	logic                      done_q;

	logic [NW-1:0]        n_eff;
	logic [STW-1:0]       step_tab [MAX_OUT];
	logic [TAB_IDX_W-1:0] tab_idx;
	logic [PW-1:0]        prod;
	logic [SW:0]          sum_ext;
	logic [SW:0]          thr_ext;
	logic [SW-1:0]        sum_nx;
	logic [SW-1:0]        thr_nx;
	logic [NW-1:0]        filled_nx;

	// Reciprocal table: entry g holds floor(2^24/(g+1))
	for (genvar g = 0; g < MAX_OUT; g++) begin : g_step
		localparam int unsigned Q = sr_pkg::ONE_Q24 / (g + 1);
		assign step_tab[g] = STW'(Q);
	end

	always_comb begin
		if (num_out_q == '0) begin
			n_eff = NW'(1);
		end else if (num_out_q > N_MAX) begin
			n_eff = N_MAX;
		end else begin
			n_eff = num_out_q;
		end
	end

	assign tab_idx   = TAB_IDX_W'(n_eff - NW'(1));
	assign prod      = PW'(uni_q) * PW'(step_q);
	assign sum_ext   = {1'b0, sum_q} + (SW + 1)'(wgt_q);
	assign thr_ext   = {1'b0, thr_q} + (SW + 1)'(step_q);
	assign sum_nx    = sum_ext[SW] ? sr_pkg::SUM_MAX : sum_ext[SW-1:0];
	assign thr_nx    = thr_ext[SW] ? sr_pkg::SUM_MAX : thr_ext[SW-1:0];
	assign filled_nx = filled_q + NW'(1);

	assign stat.in_first = first;
	assign stat.full     = filled_q >= n_eff;
	assign stat.hit      = (thr_q <= sum_q) && (filled_q < n_eff);
	assign stat.last     = !((thr_nx <= sum_q) && (filled_nx < n_eff));
	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_out_q   <= sr_pkg::NUM_OUT_RST;
			step_q      <= STEP_RST;
			sum_q       <= '0;
			thr_q       <= '0;
			filled_q    <= '0;
			pidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				num_out_q <= cfg_wr_data;
			end
			if (cmd.accept && first) begin
				sum_q    <= '0;
				filled_q <= '0;
				pidx_q   <= '0;
				step_q   <= step_tab[tab_idx];
			end
			if (cmd.mul) begin
				thr_q <= SW'(prod >> sr_pkg::UNI_W);
			end
			if (cmd.add) begin
				sum_q <= sum_nx;
			end
			if (cmd.emit) begin
				thr_q    <= thr_nx;
				filled_q <= filled_nx;
			end
			// hold the index at the top particle
			if (cmd.pidx_inc && (pidx_q != PIDX_TOP)) begin
				pidx_q <= pidx_q + PIDX_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			uni_q <= uniform;
			wgt_q <= weight;
		end
		if (cmd.emit) begin
			anc_q  <= sr_pkg::ANC_W'(pidx_q);
			slot_q <= sr_pkg::SLOT_W'(filled_q);
			last_q <= stat.last;
			done_q <= filled_nx >= n_eff;
		end
	end

	assign out_valid    = out_valid_q;
	assign ancestor     = anc_q;
	assign slot         = slot_q;
	assign last_of_item = last_q;
	assign run_done     = done_q;

endmodule

FILE: sv/systematic_resampler.sv
// Channel   Handshake              Beat contents
// input     in_valid / in_ready    first, uniform, weight
// output    out_valid / out_ready  ancestor, slot, last_of_item, run_done
// config    cfg_wr_en              cfg_wr_data (num_out), no wait
//
// One weight at a time. A weight that fills k slots goes through accept,
// accumulate and one emit step per slot; one that fills none goes through
// accept, accumulate and a closing check. A beat flagged first adds a
// multiply step; one arriving after the run is complete stops at accumulate.
// Results leave one per cycle while out_ready stays high; a low out_ready
// holds the controller in its emit state. Reset is asynchronous, no sweep.
`include "systematic_resampler_macros.svh"

module systematic_resampler #(
	parameter int unsigned MAX_PARTICLES = sr_pkg::MAX_PARTICLES_DEF,
	parameter int unsigned MAX_OUT       = sr_pkg::MAX_OUT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration: num_out
	input  logic                         cfg_wr_en,
	input  logic [sr_pkg::NUM_OUT_W-1:0] cfg_wr_data,
	// weight beats
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         first,
	input  logic [sr_pkg::UNI_W-1:0]     uniform,
	input  logic [sr_pkg::WGT_W-1:0]     weight,
	// ancestor beats
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [sr_pkg::ANC_W-1:0]     ancestor,
	output logic [sr_pkg::SLOT_W-1:0]    slot,
	output logic                         last_of_item,
	output logic                         run_done
);

	sr_pkg::sr_cmd_t  cmd;
	sr_pkg::sr_stat_t stat;

	// Controller: sequences accept, multiply, accumulate and the emit loop
	sr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: running sum, threshold, step table, slot and index counters,
	// and the output register that parts the emit loop from the consumer
	sr_dpath #(
		.MAX_PARTICLES (MAX_PARTICLES),
		.MAX_OUT       (MAX_OUT)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.first        (first),
		.uniform      (uniform),
		.weight       (weight),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.ancestor     (ancestor),
		.slot         (slot),
		.last_of_item (last_of_item),
		.run_done     (run_done),
		.cmd          (cmd),
		.stat         (stat)
	);

	// Filling the final slot always closes the weight's burst.
	`SR_ASSERT_NOW(a_done_is_last, out_valid && run_done, last_of_item,
		"run_done without last_of_item")

	// One weight in flight: no second beat right behind an accepted one.
	`SR_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready,
		"input taken twice in a row")

	// Within a burst the next result follows without a bubble.
	`SR_ASSERT_NEXT(a_burst_no_gap, out_valid && out_ready && !last_of_item, out_valid,
		"gap inside a result burst")

	// Results are only loaded while the threshold test passes.
	`SR_ASSERT_NOW(a_emit_on_hit, cmd.emit, stat.hit && stat.out_free,
		"result loaded without a hit or a free output register")

endmodule
